/* rtl/fan_tach_health_monitor_assert.svh */
// Assertion macros used by the fan tach health monitor checker.
`ifndef FAN_TACH_HEALTH_MONITOR_ASSERT_SVH
`define FAN_TACH_HEALTH_MONITOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define FTH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fan tach monitor assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define FTH_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fan tach monitor assertion failed");

`endif

/* rtl/fth_pkg.sv */
// Types, codes and the tach reciprocal table for the fan tach health monitor.
package fth_pkg;

    // request kinds; code 3 is unused and changes nothing
    localparam logic [1:0] REQ_SET_POWER = 2'd0;
    localparam logic [1:0] REQ_APPLY     = 2'd1;
    localparam logic [1:0] REQ_TACH      = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RANGE_DOUBLE_MASK = 2'd0;
    localparam logic [1:0] CFG_SPINUP_IGNORE_MS  = 2'd1;
    localparam logic [1:0] CFG_AGING_FACTOR      = 2'd2;
    localparam logic [1:0] CFG_MIN_SPIN_POWER    = 2'd3;

    localparam int CFG_DATA_W = 16;

    // reset values of the configuration registers
    localparam logic [3:0]  RST_RANGE_DOUBLE_MASK = 4'd15;
    localparam logic [15:0] RST_SPINUP_IGNORE_MS  = 16'd2000;
    localparam logic [3:0]  RST_AGING_FACTOR      = 4'd4;
    localparam logic [7:0]  RST_MIN_SPIN_POWER    = 8'd48;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  fan_index;
        logic [7:0]  power_value;
        logic [7:0]  tach_high;
        logic [31:0] time_ms;
    } fth_in_t;

    typedef struct packed {
        logic [15:0] fan_rpm;
        logic        stall_alert;
        logic        aging_alert;
        logic [7:0]  target_power;
        logic [7:0]  applied_power;
    } fth_out_t;

    // 61440 / high byte; last entry covers 0xff, which reads as zero rpm
    localparam logic [15:0] RPM_RECIP [256] = '{
        16'd0, 16'd61440, 16'd30720, 16'd20480, 16'd15360, 16'd12288, 16'd10240, 16'd8777,
        16'd7680, 16'd6827, 16'd6144, 16'd5585, 16'd5120, 16'd4726, 16'd4389, 16'd4096,
        16'd3840, 16'd3614, 16'd3413, 16'd3234, 16'd3072, 16'd2926, 16'd2793, 16'd2671,
        16'd2560, 16'd2458, 16'd2363, 16'd2276, 16'd2194, 16'd2119, 16'd2048, 16'd1982,
        16'd1920, 16'd1862, 16'd1807, 16'd1755, 16'd1707, 16'd1661, 16'd1617, 16'd1575,
        16'd1536, 16'd1499, 16'd1463, 16'd1429, 16'd1396, 16'd1365, 16'd1336, 16'd1307,
        16'd1280, 16'd1254, 16'd1229, 16'd1205, 16'd1182, 16'd1159, 16'd1138, 16'd1117,
        16'd1097, 16'd1078, 16'd1059, 16'd1041, 16'd1024, 16'd1007, 16'd991, 16'd975,
        16'd960, 16'd945, 16'd931, 16'd917, 16'd904, 16'd890, 16'd878, 16'd865,
        16'd853, 16'd842, 16'd830, 16'd819, 16'd808, 16'd798, 16'd788, 16'd778,
        16'd768, 16'd759, 16'd749, 16'd740, 16'd731, 16'd723, 16'd714, 16'd706,
        16'd698, 16'd690, 16'd683, 16'd675, 16'd668, 16'd661, 16'd654, 16'd647,
        16'd640, 16'd633, 16'd627, 16'd621, 16'd614, 16'd608, 16'd602, 16'd597,
        16'd591, 16'd585, 16'd580, 16'd574, 16'd569, 16'd564, 16'd559, 16'd554,
        16'd549, 16'd544, 16'd539, 16'd534, 16'd530, 16'd525, 16'd521, 16'd516,
        16'd512, 16'd508, 16'd504, 16'd500, 16'd495, 16'd492, 16'd488, 16'd484,
        16'd480, 16'd476, 16'd473, 16'd469, 16'd465, 16'd462, 16'd459, 16'd455,
        16'd452, 16'd448, 16'd445, 16'd442, 16'd439, 16'd436, 16'd433, 16'd430,
        16'd427, 16'd424, 16'd421, 16'd418, 16'd415, 16'd412, 16'd410, 16'd407,
        16'd404, 16'd402, 16'd399, 16'd396, 16'd394, 16'd391, 16'd389, 16'd386,
        16'd384, 16'd382, 16'd379, 16'd377, 16'd375, 16'd372, 16'd370, 16'd368,
        16'd366, 16'd364, 16'd361, 16'd359, 16'd357, 16'd355, 16'd353, 16'd351,
        16'd349, 16'd347, 16'd345, 16'd343, 16'd341, 16'd339, 16'd338, 16'd336,
        16'd334, 16'd332, 16'd330, 16'd329, 16'd327, 16'd325, 16'd323, 16'd322,
        16'd320, 16'd318, 16'd317, 16'd315, 16'd313, 16'd312, 16'd310, 16'd309,
        16'd307, 16'd306, 16'd304, 16'd303, 16'd301, 16'd300, 16'd298, 16'd297,
        16'd295, 16'd294, 16'd293, 16'd291, 16'd290, 16'd288, 16'd287, 16'd286,
        16'd284, 16'd283, 16'd282, 16'd281, 16'd279, 16'd278, 16'd277, 16'd276,
        16'd274, 16'd273, 16'd272, 16'd271, 16'd269, 16'd268, 16'd267, 16'd266,
        16'd265, 16'd264, 16'd263, 16'd261, 16'd260, 16'd259, 16'd258, 16'd257,
        16'd256, 16'd255, 16'd254, 16'd253, 16'd252, 16'd251, 16'd250, 16'd249,
        16'd248, 16'd247, 16'd246, 16'd245, 16'd244, 16'd243, 16'd242, 16'd0
    };

endpackage

/* rtl/fan_tach_health_monitor.sv */
// Fan tach health monitor: per-fan drive setpoints, tach to RPM, stall and aging alerts.
//
// Usage: each input item addresses one fan and is a set-power, apply or tach sample
// request; every item returns exactly one result item with the fan's stored rpm,
// alert flags, target and applied power after the request took effect. Throughput
// is one item per clock while out_stall is low: all per-fan state sits in
// flip-flops and each item is a single read-modify-write pass (table lookup,
// 12-bit product, 32-bit elapsed-time compare) between the input register and
// the result register. An accepted item waits in the input register and moves
// into the result register, and so onto out_valid, once that register is free.
// While out_stall holds a result, one more item fits in the input register;
// after that in_stall follows out_stall. Fan indexes at or above NUM_FANS wrap
// around. Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must do so only while idle, as the block does not enforce it.
module fan_tach_health_monitor #(
    parameter int NUM_FANS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input item channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  fth_pkg::fth_in_t               in_item,
    // result item channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output fth_pkg::fth_out_t              out_item,
    // configuration write port
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [fth_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int FAN_W = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;

    // configuration registers
    logic [3:0]  range_double_mask_reg;
    logic [15:0] spinup_ignore_ms_reg;
    logic [3:0]  aging_factor_reg;
    logic [7:0]  min_spin_power_reg;

    // two-stage pipe: input register, then result register
    logic              in_valid_reg;
    fth_pkg::fth_in_t  in_item_reg;
    logic              out_valid_reg;
    fth_pkg::fth_out_t out_item_reg;
    fth_pkg::fth_out_t out_item_next;
    logic              advance;
    logic              update_en;

    // per-fan state
    logic [7:0]  target_store_reg  [NUM_FANS];
    logic [7:0]  applied_store_reg [NUM_FANS];
    logic [31:0] power_on_time_reg [NUM_FANS];
    logic [15:0] rpm_store_reg     [NUM_FANS];
    logic        stall_flags_reg   [NUM_FANS];
    logic        aging_flags_reg   [NUM_FANS];

    logic [7:0]  target_next;
    logic [7:0]  applied_next;
    logic [31:0] power_on_time_next;
    logic [15:0] rpm_next;
    logic        stall_next;
    logic        aging_next;

    // addressed fan and its current state
    logic [4:0]       fan_ext;
    logic [FAN_W-1:0] fan_sel;
    logic [7:0]       cur_target;
    logic [7:0]       cur_applied;
    logic [31:0]      cur_pon;

    // tach sample datapath
    logic [15:0] recip;
    logic [16:0] scaled;
    logic [15:0] tach_rpm;
    logic [31:0] elapsed;
    logic        grace_done;
    logic [11:0] aging_limit;
    logic [7:0]  clamped_power;

    // result register frees when empty or taken this cycle
    assign advance   = !out_valid_reg || !out_stall;
    assign update_en = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_double_mask_reg <= fth_pkg::RST_RANGE_DOUBLE_MASK;
            spinup_ignore_ms_reg  <= fth_pkg::RST_SPINUP_IGNORE_MS;
            aging_factor_reg      <= fth_pkg::RST_AGING_FACTOR;
            min_spin_power_reg    <= fth_pkg::RST_MIN_SPIN_POWER;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fth_pkg::CFG_RANGE_DOUBLE_MASK: range_double_mask_reg <= cfg_data[3:0];
                fth_pkg::CFG_SPINUP_IGNORE_MS:  spinup_ignore_ms_reg  <= cfg_data[15:0];
                fth_pkg::CFG_AGING_FACTOR:      aging_factor_reg      <= cfg_data[3:0];
                fth_pkg::CFG_MIN_SPIN_POWER:    min_spin_power_reg    <= cfg_data[7:0];
            endcase
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_item;
        end
        if (update_en)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // index wraps modulo NUM_FANS; a 2-bit index is below twice any legal count
    assign fan_ext = (5'(in_item_reg.fan_index) >= 5'(NUM_FANS))
                   ? 5'(in_item_reg.fan_index) - 5'(NUM_FANS)
                   : 5'(in_item_reg.fan_index);
    assign fan_sel = fan_ext[FAN_W-1:0];

    assign cur_target  = target_store_reg[fan_sel];
    assign cur_applied = applied_store_reg[fan_sel];
    assign cur_pon     = power_on_time_reg[fan_sel];

    // rpm: reciprocal, optional doubling, saturate to 16 bits
    assign recip    = fth_pkg::RPM_RECIP[in_item_reg.tach_high];
    assign scaled   = range_double_mask_reg[fan_ext[1:0]] ? {recip, 1'b0} : {1'b0, recip};
    assign tach_rpm = scaled[16] ? 16'hffff : scaled[15:0];

    // wrapping elapsed time since power-on
    assign elapsed     = in_item_reg.time_ms - cur_pon;
    assign grace_done  = elapsed >= {16'd0, spinup_ignore_ms_reg};
    assign aging_limit = 12'(aging_factor_reg) * 12'(cur_applied);

    // small nonzero requests get lifted to the minimum spin level
    assign clamped_power = (in_item_reg.power_value != 8'd0
                            && in_item_reg.power_value < min_spin_power_reg)
                         ? min_spin_power_reg : in_item_reg.power_value;

    always_comb
    begin
        target_next        = cur_target;
        applied_next       = cur_applied;
        power_on_time_next = cur_pon;
        rpm_next           = rpm_store_reg[fan_sel];
        stall_next         = stall_flags_reg[fan_sel];
        aging_next         = aging_flags_reg[fan_sel];
        unique case (in_item_reg.req_type)
            fth_pkg::REQ_SET_POWER:
            begin
                target_next = clamped_power;
            end
            fth_pkg::REQ_APPLY:
            begin
                // record power-on only on a zero to nonzero transition
                if (cur_applied == 8'd0 && cur_target != 8'd0)
                begin
                    power_on_time_next = in_item_reg.time_ms;
                end
                applied_next = cur_target;
            end
            fth_pkg::REQ_TACH:
            begin
                rpm_next   = tach_rpm;
                stall_next = 1'b0;
                aging_next = 1'b0;
                if (cur_applied != 8'd0 && grace_done)
                begin
                    if (tach_rpm == 16'd0)
                    begin
                        stall_next = 1'b1;
                    end
                    else if ({4'd0, aging_limit} > tach_rpm)
                    begin
                        aging_next = 1'b1;
                    end
                end
            end
            default:
            begin
                // unused request code: status only
            end
        endcase

        out_item_next.fan_rpm       = rpm_next;
        out_item_next.stall_alert   = stall_next;
        out_item_next.aging_alert   = aging_next;
        out_item_next.target_power  = target_next;
        out_item_next.applied_power = applied_next;
    end

    // per-fan state write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FANS; i++)
            begin
                target_store_reg[i]  <= 8'd0;
                applied_store_reg[i] <= 8'd0;
                power_on_time_reg[i] <= 32'd0;
                rpm_store_reg[i]     <= 16'd0;
                stall_flags_reg[i]   <= 1'b0;
                aging_flags_reg[i]   <= 1'b0;
            end
        end
        else if (update_en)
        begin
            target_store_reg[fan_sel]  <= target_next;
            applied_store_reg[fan_sel] <= applied_next;
            power_on_time_reg[fan_sel] <= power_on_time_next;
            rpm_store_reg[fan_sel]     <= rpm_next;
            stall_flags_reg[fan_sel]   <= stall_next;
            aging_flags_reg[fan_sel]   <= aging_next;
        end
    end

endmodule

/* rtl/fth_checker.sv */
// Port-level checker for the fan tach health monitor, bound to the top level.
`include "fan_tach_health_monitor_assert.svh"

module fth_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input fth_pkg::fth_out_t out_item
);

    // a stalled result stays put
    `FTH_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

    // the two alerts exclude each other
    `FTH_ASSERT_IMP(a_alert_excl, out_valid, !(out_item.stall_alert && out_item.aging_alert))

    // stall is only raised on a zero reading, stored with it
    `FTH_ASSERT_IMP(a_stall_rpm, out_valid && out_item.stall_alert, out_item.fan_rpm == 16'd0)

    // aging needs a nonzero reading
    `FTH_ASSERT_IMP(a_aging_rpm, out_valid && out_item.aging_alert, out_item.fan_rpm != 16'd0)

endmodule

bind fan_tach_health_monitor fth_checker u_fth_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

/* sim/tb.sv */
// Testbench for the fan tach health monitor: queued random and directed items, scoreboard check.
module tb;

    localparam int NUM_FANS       = 4;
    localparam int WATCHDOG_LIMIT = 2000;   // idle cycles before giving up
    localparam int HOLD_CYCLES    = 300;    // long receiver back-pressure stretch
    localparam int HOLD_AT_RESULT = 150;    // result count that starts the stretch
    localparam int DRAIN_CYCLES   = 10;     // settle time after the last result
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    fth_pkg::fth_in_t  in_item = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    fth_pkg::fth_out_t out_item;
    logic                           cfg_write = 1'b0;
    logic [1:0]                     cfg_index = fth_pkg::CFG_RANGE_DOUBLE_MASK;
    logic [fth_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    fan_tach_health_monitor #(.NUM_FANS(NUM_FANS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial forever #10 clk = ~clk;

    // Shadow copy of the configuration, kept in step with every register write.
    logic [3:0]  dbl_mask_cfg   = fth_pkg::RST_RANGE_DOUBLE_MASK;
    logic [15:0] grace_ms_cfg   = fth_pkg::RST_SPINUP_IGNORE_MS;
    logic [3:0]  aging_k_cfg    = fth_pkg::RST_AGING_FACTOR;
    logic [7:0]  min_spin_cfg   = fth_pkg::RST_MIN_SPIN_POWER;

    // Shadow per-fan state.
    logic [7:0]  tgt_pwr     [NUM_FANS];
    logic [7:0]  drive_pwr   [NUM_FANS];
    logic [31:0] spin_start  [NUM_FANS];
    logic [15:0] meas_rpm    [NUM_FANS];
    logic        stall_flag  [NUM_FANS];
    logic        aging_flag  [NUM_FANS];

    fth_pkg::fth_in_t  pending_items   [$];
    fth_pkg::fth_out_t expected_status [$];

    int                fail_count   = 0;
    int                sent_count   = 0;
    int                results_seen = 0;
    int                send_idle    = 0;
    int                recv_wait    = 0;
    int                hold_left    = 0;
    bit                hold_done    = 1'b0;
    int                idle_cycles  = 0;
    logic [31:0]       gen_now      = '0;
    fth_pkg::fth_out_t want;

    initial
    begin
        for (int f = 0; f < NUM_FANS; f++)
        begin
            tgt_pwr[f]    = '0;
            drive_pwr[f]  = '0;
            spin_start[f] = '0;
            meas_rpm[f]   = '0;
            stall_flag[f] = 1'b0;
            aging_flag[f] = 1'b0;
        end
    end

    // Tach high byte to rpm: 61440 / byte, rounded; 0xff means no pulses.
    function automatic logic [15:0] recip_speed(logic [7:0] hb, logic dbl);
        int base;
        if (hb == 8'hff || hb == 8'h00)
            return 16'd0;
        base = (61440 + int'(hb) / 2) / int'(hb);
        if (dbl)
            base = base * 2;
        if (base > 65535)
            base = 65535;
        return base[15:0];
    endfunction

    // Applies one item to the shadow state, returns the status the block must report.
    function automatic fth_pkg::fth_out_t predict_fan_status(fth_pkg::fth_in_t it);
        int                fan;
        logic [7:0]        pwr;
        logic              dbl;
        logic [15:0]       rpm;
        logic [31:0]       elapsed;
        fth_pkg::fth_out_t r;
        fan = int'(it.fan_index) % NUM_FANS;
        unique case (it.req_type)
            fth_pkg::REQ_SET_POWER:
            begin
                pwr = it.power_value;
                if (pwr != 0 && pwr < min_spin_cfg)
                    pwr = min_spin_cfg;
                tgt_pwr[fan] = pwr;
            end
            fth_pkg::REQ_APPLY:
            begin
                // power-on time only latched on a zero to nonzero step
                if (drive_pwr[fan] == 0 && tgt_pwr[fan] != 0)
                    spin_start[fan] = it.time_ms;
                drive_pwr[fan] = tgt_pwr[fan];
            end
            fth_pkg::REQ_TACH:
            begin
                dbl = (fan < 4) ? dbl_mask_cfg[fan] : 1'b0;
                rpm = recip_speed(it.tach_high, dbl);
                elapsed = it.time_ms - spin_start[fan];
                meas_rpm[fan] = rpm;
                stall_flag[fan] = 1'b0;
                aging_flag[fan] = 1'b0;
                if (drive_pwr[fan] != 0 && elapsed >= {16'd0, grace_ms_cfg})
                begin
                    if (rpm == 0)
                        stall_flag[fan] = 1'b1;
                    else if (int'(rpm) < int'(aging_k_cfg) * int'(drive_pwr[fan]))
                        aging_flag[fan] = 1'b1;
                end
            end
            default: ;
        endcase
        r.fan_rpm       = meas_rpm[fan];
        r.stall_alert   = stall_flag[fan];
        r.aging_alert   = aging_flag[fan];
        r.target_power  = tgt_pwr[fan];
        r.applied_power = drive_pwr[fan];
        return r;
    endfunction

    // Sender: presents queued items, random gap after each, holds payload while stalled.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_status.push_back(predict_fan_status(in_item));
            if (!(in_valid && in_stall))
            begin
                if (send_idle > 0)
                begin
                    send_idle--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    in_item  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    sent_count++;
                    // every 64 items, a stretch of 16 goes back to back
                    if (sent_count % 64 < 16 || $urandom_range(0, 1) == 0)
                        send_idle = 0;
                    else
                        send_idle = $urandom_range(0, 18);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result against the oldest expectation, draws its own stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_status.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"ERROR: unexpected result rpm=%0d stall=%0b aging=%0b ",
                                  "tgt=%0d app=%0d"},
                                 out_item.fan_rpm, out_item.stall_alert, out_item.aging_alert,
                                 out_item.target_power, out_item.applied_power);
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (out_item.fan_rpm !== want.fan_rpm
                        || out_item.stall_alert !== want.stall_alert
                        || out_item.aging_alert !== want.aging_alert
                        || out_item.target_power !== want.target_power
                        || out_item.applied_power !== want.applied_power)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"ERROR: result %0d expected rpm=%0d stall=%0b aging=%0b ",
                                      "tgt=%0d app=%0d, got rpm=%0d stall=%0b aging=%0b ",
                                      "tgt=%0d app=%0d"},
                                     results_seen, want.fan_rpm, want.stall_alert,
                                     want.aging_alert, want.target_power, want.applied_power,
                                     out_item.fan_rpm, out_item.stall_alert,
                                     out_item.aging_alert, out_item.target_power,
                                     out_item.applied_power);
                    end
                end
                if (results_seen % 64 >= 32 && results_seen % 64 < 48)
                    recv_wait = 0;
                else if ($urandom_range(0, 1) == 0)
                    recv_wait = 0;
                else
                    recv_wait = $urandom_range(0, 18);
            end
            // one long back-pressure stretch so the block fills and stalls its input
            if (!hold_done && results_seen >= HOLD_AT_RESULT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic add_item(logic [1:0] kind, logic [1:0] fan, logic [7:0] pwr,
                            logic [7:0] tach, logic [31:0] t);
        fth_pkg::fth_in_t it;
        it.req_type    = kind;
        it.fan_index   = fan;
        it.power_value = pwr;
        it.tach_high   = tach;
        it.time_ms     = t;
        pending_items.push_back(it);
    endtask

    // Block until every queued item went in and every result came back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_status.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic program_regs(logic [3:0] mask, logic [15:0] grace, logic [3:0] k,
                                logic [7:0] minp);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= fth_pkg::CFG_RANGE_DOUBLE_MASK;
        cfg_data  <= {12'd0, mask};
        @(posedge clk);
        cfg_index <= fth_pkg::CFG_SPINUP_IGNORE_MS;
        cfg_data  <= grace;
        @(posedge clk);
        cfg_index <= fth_pkg::CFG_AGING_FACTOR;
        cfg_data  <= {12'd0, k};
        @(posedge clk);
        cfg_index <= fth_pkg::CFG_MIN_SPIN_POWER;
        cfg_data  <= {8'd0, minp};
        @(posedge clk);
        cfg_write <= 1'b0;
        dbl_mask_cfg = mask;
        grace_ms_cfg = grace;
        aging_k_cfg  = k;
        min_spin_cfg = minp;
        @(negedge clk);
    endtask

    // Mostly power-up sequences per fan (set, apply, tach samples across the grace
    // window), with some lone requests and fully random noise mixed in.
    task automatic add_random_items(int n);
        int          made;
        int          sel;
        int          reps;
        logic [1:0]  fan;
        logic [7:0]  pwr;
        logic [7:0]  tach;
        made = 0;
        while (made < n)
        begin
            sel = $urandom_range(0, 9);
            fan = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 15) == 0)
                gen_now = $urandom;   // jump, also lands near the wrap point
            if (sel < 6)
            begin
                case ($urandom_range(0, 3))
                    0:       pwr = 8'd0;
                    1:       pwr = 8'($urandom_range(0, int'(min_spin_cfg)));
                    default: pwr = 8'($urandom_range(0, 255));
                endcase
                add_item(fth_pkg::REQ_SET_POWER, fan, pwr, 8'($urandom_range(0, 255)),
                         $urandom);
                gen_now = gen_now + $urandom_range(0, 50);
                add_item(fth_pkg::REQ_APPLY, fan, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), gen_now);
                reps = $urandom_range(1, 4);
                made += 2 + reps;
                repeat (reps)
                begin
                    gen_now = gen_now + $urandom_range(0, int'(grace_ms_cfg) * 3 / 4 + 1);
                    case ($urandom_range(0, 4))
                        0:       tach = 8'hff;
                        1:       tach = 8'($urandom_range(0, 4));
                        2:       tach = 8'($urandom_range(200, 254));
                        default: tach = 8'($urandom_range(0, 255));
                    endcase
                    add_item(fth_pkg::REQ_TACH, fan, 8'($urandom_range(0, 255)), tach, gen_now);
                end
            end
            else if (sel < 8)
            begin
                gen_now = gen_now + $urandom_range(0, int'(grace_ms_cfg) + 1);
                add_item(2'($urandom_range(0, 2)), fan, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), gen_now);
                made++;
            end
            else
            begin
                add_item(2'($urandom_range(0, 3)), fan, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), $urandom);
                made++;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under reset configuration.
        add_item(fth_pkg::REQ_TACH, 2'd0, 8'd0, 8'h00, 32'd0);            // undriven, zero byte
        add_item(fth_pkg::REQ_TACH, 2'd0, 8'd0, 8'hff, 32'hffff_ffff);    // no pulses reads zero
        add_item(fth_pkg::REQ_TACH, 2'd0, 8'd0, 8'h01, 32'd0);            // doubled, saturates
        add_item(fth_pkg::REQ_SET_POWER, 2'd1, 8'd1, 8'd0, 32'd0);        // raised to minimum
        add_item(fth_pkg::REQ_SET_POWER, 2'd1, 8'd47, 8'd0, 32'd0);
        add_item(fth_pkg::REQ_SET_POWER, 2'd1, 8'd48, 8'd0, 32'd0);
        add_item(fth_pkg::REQ_APPLY, 2'd1, 8'd0, 8'd0, 32'hffff_f000);    // power-on near wrap
        add_item(fth_pkg::REQ_APPLY, 2'd1, 8'd0, 8'd0, 32'd5);            // already on
        add_item(fth_pkg::REQ_TACH, 2'd1, 8'd0, 8'hff, 32'hffff_f100);    // in grace, no alert
        add_item(fth_pkg::REQ_TACH, 2'd1, 8'd0, 8'hff, 32'h0000_03e0);    // past grace: stall
        add_item(fth_pkg::REQ_TACH, 2'd1, 8'd0, 8'd254, 32'h0000_03e0);   // flags clear
        add_item(fth_pkg::REQ_SET_POWER, 2'd3, 8'd255, 8'd0, 32'd0);
        add_item(fth_pkg::REQ_APPLY, 2'd3, 8'd0, 8'd0, 32'd0);
        add_item(fth_pkg::REQ_TACH, 2'd3, 8'd0, 8'd254, 32'd1999);        // one ms short
        add_item(fth_pkg::REQ_TACH, 2'd3, 8'd0, 8'd254, 32'd2000);        // grace met: aging
        add_item(fth_pkg::REQ_TACH, 2'd3, 8'd0, 8'd2, 32'd2000);          // healthy speed
        add_item(REQ_UNUSED, 2'd2, 8'haa, 8'h55, 32'h1234_5678);          // changes nothing
        add_item(fth_pkg::REQ_SET_POWER, 2'd2, 8'd0, 8'd0, 32'd0);        // zero stays zero
        add_item(fth_pkg::REQ_APPLY, 2'd2, 8'd0, 8'd0, 32'd100);          // stays off
        add_item(fth_pkg::REQ_TACH, 2'd2, 8'd0, 8'hff, 32'h8000_0000);    // undriven, no stall
        add_item(fth_pkg::REQ_SET_POWER, 2'd1, 8'd0, 8'd0, 32'd0);
        add_item(fth_pkg::REQ_APPLY, 2'd1, 8'd0, 8'd0, 32'h0000_1000);    // power off
        add_item(fth_pkg::REQ_TACH, 2'd1, 8'd0, 8'hff, 32'h0000_2000);    // off clears stall
        add_item(fth_pkg::REQ_APPLY, 2'd3, 8'd0, 8'd0, 32'd7);
        wait_drained();

        // Extremes first, then moderate and random settings.
        program_regs(4'd0, 16'd0, 4'd15, 8'd255);
        add_random_items(100);
        wait_drained();
        program_regs(4'd15, 16'd65535, 4'd0, 8'd0);
        add_random_items(100);
        wait_drained();
        program_regs(4'b1010, 16'd500, 4'd8, 8'd100);
        add_random_items(100);
        wait_drained();
        repeat (2)
        begin
            program_regs(4'($urandom_range(0, 15)), 16'($urandom_range(0, 4000)),
                         4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            add_random_items(100);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_status.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
